### design/dsrm_pkg.sv
package dsrm_pkg;

    localparam int IN_DATA_W  = 168;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 3;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] OUTCOME_TIMEOUT = 2'd0;
    localparam logic [1:0] OUTCOME_ACCEPT  = 2'd1;
    localparam logic [1:0] OUTCOME_REJECT  = 2'd2;

    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_IGNORE = 8'hFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  rx_byte;
        logic [63:0] accept_pattern;
        logic [3:0]  accept_length;
        logic [63:0] reject_pattern;
        logic [3:0]  reject_length;
        logic [15:0] timeout_ticks;
        logic [4:0]  capture_size;
    } item_t;

    typedef struct packed {
        logic       done_res;
        logic [1:0] outcome;
        logic       byte_valid;
        logic [7:0] captured_byte;
    } result_t;

endpackage

### design/dsrm_in_stage.sv
module dsrm_in_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // rx_byte, accept_pattern, accept_length, reject_pattern, reject_length,
    // timeout_ticks, capture_size, zero pad
    input  logic [dsrm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [dsrm_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                            item_take,
    output logic                            item_valid,
    output dsrm_pkg::item_t                 item
);

    logic            valid_reg;
    logic            valid_next;
    logic            load;
    dsrm_pkg::item_t item_reg;
    dsrm_pkg::item_t item_next;

    assign s_axis_tready = !valid_reg || item_take;
    assign load          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        item_next.command        = s_axis_tuser[1:0];
        item_next.rx_byte        = s_axis_tdata[7:0];
        item_next.accept_pattern = s_axis_tdata[71:8];
        item_next.accept_length  = s_axis_tdata[75:72];
        item_next.reject_pattern = s_axis_tdata[139:76];
        item_next.reject_length  = s_axis_tdata[143:140];
        item_next.timeout_ticks  = s_axis_tdata[159:144];
        item_next.capture_size   = s_axis_tdata[164:160];
    end

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### design/dsrm_core.sv
module dsrm_core #(
    parameter int PATTERN_BYTES = 8,
    parameter int CAPTURE_MAX   = 16,
    parameter int TIMEOUT_BITS  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  dsrm_pkg::item_t   item,
    output logic              res_valid,
    output dsrm_pkg::result_t res
);

    localparam int PAT_W  = PATTERN_BYTES * 8;
    localparam int IDX_W  = $clog2(PATTERN_BYTES + 1);
    localparam int CS_W   = $clog2(CAPTURE_MAX + 1);
    localparam int TL_W   = TIMEOUT_BITS + 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MATCH,
        PH_CAPTURE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [IDX_W-1:0]   a_idx_reg, a_idx_next;
    logic [IDX_W-1:0]   r_idx_reg, r_idx_next;
    logic [TL_W-1:0]    ticks_reg, ticks_next;
    logic [CS_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]   a_len_reg, a_len_next;
    logic [IDX_W-1:0]   r_len_reg, r_len_next;
    logic [CS_W-1:0]    csize_reg, csize_next;
    logic [PAT_W-1:0]   a_pat_reg, a_pat_next;
    logic [PAT_W-1:0]   r_pat_reg, r_pat_next;

    logic [7:0]         a_byte;
    logic [7:0]         r_byte;
    logic [IDX_W-1:0]   a_idx_inc;
    logic [IDX_W-1:0]   r_idx_inc;
    logic [CS_W-1:0]    count_inc;
    logic [TL_W-1:0]    ticks_dec;
    logic [32:0]        tmo_load;
    logic               a_done;
    logic               r_done;
    logic [7:0]         b;

    assign b         = item.rx_byte;
    assign a_idx_inc = a_idx_reg + IDX_W'(1);
    assign r_idx_inc = r_idx_reg + IDX_W'(1);
    assign count_inc = count_reg + CS_W'(1);
    assign ticks_dec = (ticks_reg != '0) ? ticks_reg - TL_W'(1) : '0;
    assign tmo_load  = ({17'd0, item.timeout_ticks}
                        & ((33'd1 << TIMEOUT_BITS) - 33'd1)) + 33'd1;

    always_comb
    begin
        a_byte = '0;
        r_byte = '0;
        for (int i = 0; i < PATTERN_BYTES; i++)
        begin
            if (a_idx_reg == IDX_W'(i))
            begin
                a_byte = a_pat_reg[i*8 +: 8];
            end
            if (r_idx_reg == IDX_W'(i))
            begin
                r_byte = r_pat_reg[i*8 +: 8];
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        a_idx_next = a_idx_reg;
        r_idx_next = r_idx_reg;
        ticks_next = ticks_reg;
        count_next = count_reg;
        a_len_next = a_len_reg;
        r_len_next = r_len_reg;
        csize_next = csize_reg;
        a_pat_next = a_pat_reg;
        r_pat_next = r_pat_reg;
        a_done     = 1'b0;
        r_done     = 1'b0;
        res_valid  = 1'b0;
        res        = '0;

        if (step)
        begin
            unique case (item.command)
                dsrm_pkg::CMD_START:
                begin
                    a_pat_next = item.accept_pattern[PAT_W-1:0];
                    r_pat_next = item.reject_pattern[PAT_W-1:0];
                    a_len_next = (item.accept_length > 4'(PATTERN_BYTES))
                                 ? IDX_W'(PATTERN_BYTES) : IDX_W'(item.accept_length);
                    r_len_next = (item.reject_length > 4'(PATTERN_BYTES))
                                 ? IDX_W'(PATTERN_BYTES) : IDX_W'(item.reject_length);
                    csize_next = ({3'd0, item.capture_size} > 8'(CAPTURE_MAX))
                                 ? CS_W'(CAPTURE_MAX) : CS_W'(item.capture_size);
                    ticks_next = tmo_load[TL_W-1:0];
                    a_idx_next = '0;
                    r_idx_next = '0;
                    count_next = '0;
                    phase_next = PH_MATCH;
                end
                dsrm_pkg::CMD_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        ticks_next = ticks_dec;
                        if (ticks_dec == '0)
                        begin
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                            res.outcome  = (phase_reg == PH_CAPTURE)
                                           ? dsrm_pkg::OUTCOME_ACCEPT
                                           : dsrm_pkg::OUTCOME_TIMEOUT;
                            phase_next   = PH_IDLE;
                        end
                    end
                end
                dsrm_pkg::CMD_BYTE:
                begin
                    if (phase_reg == PH_MATCH)
                    begin
                        if (b != dsrm_pkg::BYTE_IGNORE && a_len_reg != '0)
                        begin
                            if (b == a_byte)
                            begin
                                a_idx_next = a_idx_inc;
                                a_done     = (a_idx_inc == a_len_reg);
                            end
                            else
                            begin
                                a_idx_next = '0;
                            end
                            if (r_len_reg != '0)
                            begin
                                if (b == r_byte)
                                begin
                                    r_idx_next = r_idx_inc;
                                    r_done     = (r_idx_inc == r_len_reg);
                                end
                                else
                                begin
                                    r_idx_next = '0;
                                end
                            end
                            if (r_done)
                            begin
                                res_valid    = 1'b1;
                                res.done_res = 1'b1;
                                res.outcome  = dsrm_pkg::OUTCOME_REJECT;
                                phase_next   = PH_IDLE;
                            end
                            else if (a_done)
                            begin
                                if (csize_reg == '0)
                                begin
                                    res_valid    = 1'b1;
                                    res.done_res = 1'b1;
                                    res.outcome  = dsrm_pkg::OUTCOME_ACCEPT;
                                    phase_next   = PH_IDLE;
                                end
                                else
                                begin
                                    count_next = '0;
                                    phase_next = PH_CAPTURE;
                                end
                            end
                        end
                    end
                    else if (phase_reg == PH_CAPTURE)
                    begin
                        if (b == dsrm_pkg::BYTE_CR || b == dsrm_pkg::BYTE_LF)
                        begin
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                            res.outcome  = dsrm_pkg::OUTCOME_ACCEPT;
                            phase_next   = PH_IDLE;
                        end
                        else if (b != dsrm_pkg::BYTE_IGNORE)
                        begin
                            count_next        = count_inc;
                            res_valid         = 1'b1;
                            res.byte_valid    = 1'b1;
                            res.captured_byte = b;
                            if (count_inc >= csize_reg)
                            begin
                                res.done_res = 1'b1;
                                res.outcome  = dsrm_pkg::OUTCOME_ACCEPT;
                                phase_next   = PH_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            a_idx_reg <= '0;
            r_idx_reg <= '0;
            ticks_reg <= '0;
            count_reg <= '0;
            a_len_reg <= '0;
            r_len_reg <= '0;
            csize_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            a_idx_reg <= a_idx_next;
            r_idx_reg <= r_idx_next;
            ticks_reg <= ticks_next;
            count_reg <= count_next;
            a_len_reg <= a_len_next;
            r_len_reg <= r_len_next;
            csize_reg <= csize_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_pat_reg <= a_pat_next;
        r_pat_reg <= r_pat_next;
    end

endmodule

### design/dsrm_out_stage.sv
module dsrm_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  dsrm_pkg::result_t               res,
    output logic                            slot_free,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // captured_byte
    output logic [dsrm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // outcome, byte_valid
    output logic [dsrm_pkg::OUT_USER_W-1:0] m_axis_tuser,
    // done_res
    output logic                            m_axis_tlast
);

    logic              valid_reg;
    logic              valid_next;
    dsrm_pkg::result_t res_reg;

    assign slot_free = !valid_reg || m_axis_tready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = res_reg.captured_byte;
    assign m_axis_tuser  = {res_reg.byte_valid, res_reg.outcome};
    assign m_axis_tlast  = res_reg.done_res;

endmodule

### design/dual_string_response_matcher.sv
// Response matcher: watches a received byte stream for an accept and a reject string.
// Input stream (s_axis): tuser carries the command (start, received byte, one tick);
// tdata carries the received byte and, for a start, both strings, their lengths,
// the tick timeout and the capture size. An item is taken when tvalid and tready
// are both high.
// Output stream (m_axis): tlast marks the item that finishes a wait, tuser carries
// the outcome (timeout, accept, reject) and the captured-byte flag, tdata carries
// the captured reply byte. Starts, idle bytes and most ticks give no output item.
// Timing: an item taken is held in the input register; its result, if any, enters the
// output register as the item leaves the input register, when that slot is free.
// Throughput: one item per cycle while the output slot is free; each item costs two
// indexed byte compares and counter updates between the input and output registers.
// Reset: clears both handshake stages and returns the matcher to idle, where bytes
// and ticks are dropped until a start arrives.
// Stall: while the output register holds an untaken item, the input register
// still takes one more item and then holds it until the output side frees up.
module dual_string_response_matcher #(
    parameter int PATTERN_BYTES = 8,
    parameter int CAPTURE_MAX   = 16,
    parameter int TIMEOUT_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // rx_byte, accept_pattern, accept_length, reject_pattern, reject_length,
    // timeout_ticks, capture_size, zero pad
    input  logic [dsrm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [dsrm_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // captured_byte
    output logic [dsrm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // outcome, byte_valid
    output logic [dsrm_pkg::OUT_USER_W-1:0] m_axis_tuser,
    // done_res
    output logic                            m_axis_tlast
);

    dsrm_pkg::item_t   item;
    dsrm_pkg::result_t res;
    logic              item_valid;
    logic              item_take;
    logic              slot_free;
    logic              res_valid;

    assign item_take = item_valid && slot_free;

    dsrm_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_take     (item_take),
        .item_valid    (item_valid),
        .item          (item)
    );

    dsrm_core #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .CAPTURE_MAX   (CAPTURE_MAX),
        .TIMEOUT_BITS  (TIMEOUT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (item_take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    dsrm_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (item_take && res_valid),
        .res           (res),
        .slot_free     (slot_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_done_byte_is_accept: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] && m_axis_tlast
        |-> m_axis_tuser[1:0] == dsrm_pkg::OUTCOME_ACCEPT)
        else $error("captured byte finishing a wait without accept outcome");

    a_open_item_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast
        |-> m_axis_tuser[2] && m_axis_tuser[1:0] == dsrm_pkg::OUTCOME_TIMEOUT)
        else $error("non-final output item without a captured byte");

    a_no_byte_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata == '0)
        else $error("captured byte data set without byte flag");

endmodule

### bench/tb.sv
module tb;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [3:0] PAT_MAX      = 4'd8;
    localparam logic [4:0] CAP_MAX      = 5'd16;
    localparam int         RANDOM_ITEMS = 1600;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         LIMIT_CYCLES = 1000000;

    typedef enum logic [1:0] {WAIT_IDLE, WAIT_MATCH, WAIT_CAPTURE} wait_state_t;
    typedef enum logic [1:0] {ROW_PREDICTED, ROW_SILENT, ROW_FIXED} row_kind_t;

    typedef struct {
        dsrm_pkg::item_t   it;
        row_kind_t         kind;
        dsrm_pkg::result_t want;
    } row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [dsrm_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [dsrm_pkg::IN_USER_W-1:0]  s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [dsrm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [dsrm_pkg::OUT_USER_W-1:0] m_axis_tuser;
    logic                            m_axis_tlast;

    dual_string_response_matcher #(
        .PATTERN_BYTES(8),
        .CAPTURE_MAX  (16),
        .TIMEOUT_BITS (16)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    wait_state_t wait_state = WAIT_IDLE;
    logic [3:0]  acc_pos    = '0;
    logic [3:0]  rej_pos    = '0;
    logic [16:0] ticks_left = '0;
    logic [4:0]  cap_count  = '0;
    logic [63:0] held_acc   = '0;
    logic [63:0] held_rej   = '0;
    logic [3:0]  acc_len    = '0;
    logic [3:0]  rej_len    = '0;
    logic [4:0]  cap_size   = '0;

    dsrm_pkg::result_t pending_responses[$];
    int                mismatch_count = 0;
    int                results_seen   = 0;
    int                cycle_count    = 0;

    function automatic bit matcher_response(input dsrm_pkg::item_t it,
                                            output dsrm_pkg::result_t res);
        bit         hit_accept;
        bit         hit_reject;
        logic [7:0] b;
        res = '0;
        hit_accept = 1'b0;
        hit_reject = 1'b0;
        b = it.rx_byte;
        if (it.command == dsrm_pkg::CMD_START)
        begin
            held_acc = it.accept_pattern;
            held_rej = it.reject_pattern;
            acc_len = (it.accept_length > PAT_MAX) ? PAT_MAX : it.accept_length;
            rej_len = (it.reject_length > PAT_MAX) ? PAT_MAX : it.reject_length;
            cap_size = (it.capture_size > CAP_MAX) ? CAP_MAX : it.capture_size;
            ticks_left = {1'b0, it.timeout_ticks} + 17'd1;
            acc_pos = '0;
            rej_pos = '0;
            cap_count = '0;
            wait_state = WAIT_MATCH;
            return 1'b0;
        end
        if (wait_state == WAIT_IDLE || it.command == CMD_UNUSED)
            return 1'b0;
        if (it.command == dsrm_pkg::CMD_TICK)
        begin
            if (ticks_left != 0)
                ticks_left = ticks_left - 17'd1;
            if (ticks_left == 0)
            begin
                res.done_res = 1'b1;
                res.outcome = (wait_state == WAIT_CAPTURE) ? dsrm_pkg::OUTCOME_ACCEPT
                                                           : dsrm_pkg::OUTCOME_TIMEOUT;
                wait_state = WAIT_IDLE;
                return 1'b1;
            end
            return 1'b0;
        end
        if (wait_state == WAIT_MATCH)
        begin
            if (b == dsrm_pkg::BYTE_IGNORE || acc_len == 0)
                return 1'b0;
            if (b == held_acc[8*acc_pos[2:0] +: 8])
            begin
                acc_pos = acc_pos + 4'd1;
                hit_accept = (acc_pos == acc_len);
            end
            else
                acc_pos = '0;
            if (rej_len != 0)
            begin
                if (b == held_rej[8*rej_pos[2:0] +: 8])
                begin
                    rej_pos = rej_pos + 4'd1;
                    hit_reject = (rej_pos == rej_len);
                end
                else
                    rej_pos = '0;
            end
            if (hit_reject)
            begin
                res.done_res = 1'b1;
                res.outcome = dsrm_pkg::OUTCOME_REJECT;
                wait_state = WAIT_IDLE;
                return 1'b1;
            end
            if (hit_accept)
            begin
                if (cap_size == 0)
                begin
                    res.done_res = 1'b1;
                    res.outcome = dsrm_pkg::OUTCOME_ACCEPT;
                    wait_state = WAIT_IDLE;
                    return 1'b1;
                end
                cap_count = '0;
                wait_state = WAIT_CAPTURE;
            end
            return 1'b0;
        end
        if (b == dsrm_pkg::BYTE_CR || b == dsrm_pkg::BYTE_LF)
        begin
            res.done_res = 1'b1;
            res.outcome = dsrm_pkg::OUTCOME_ACCEPT;
            wait_state = WAIT_IDLE;
            return 1'b1;
        end
        if (b == dsrm_pkg::BYTE_IGNORE)
            return 1'b0;
        cap_count = cap_count + 5'd1;
        res.byte_valid = 1'b1;
        res.captured_byte = b;
        if (cap_count >= cap_size)
        begin
            res.done_res = 1'b1;
            res.outcome = dsrm_pkg::OUTCOME_ACCEPT;
            wait_state = WAIT_IDLE;
        end
        return 1'b1;
    endfunction

    function automatic dsrm_pkg::item_t random_item();
        dsrm_pkg::item_t it;
        it.command = 2'($urandom_range(0, 3));
        it.rx_byte = 8'($urandom);
        it.accept_pattern = {$urandom, $urandom};
        it.accept_length = 4'($urandom);
        it.reject_pattern = {$urandom, $urandom};
        it.reject_length = 4'($urandom);
        it.timeout_ticks = 16'($urandom);
        it.capture_size = 5'($urandom);
        return it;
    endfunction

    function automatic dsrm_pkg::item_t start_item(input logic [63:0] apat,
                                                   input logic [3:0] alen,
                                                   input logic [63:0] rpat,
                                                   input logic [3:0] rlen,
                                                   input logic [15:0] tmo,
                                                   input logic [4:0] cap);
        dsrm_pkg::item_t it;
        it = '0;
        it.command = dsrm_pkg::CMD_START;
        it.accept_pattern = apat;
        it.accept_length = alen;
        it.reject_pattern = rpat;
        it.reject_length = rlen;
        it.timeout_ticks = tmo;
        it.capture_size = cap;
        return it;
    endfunction

    function automatic dsrm_pkg::item_t rx_item(input logic [1:0] cmd, input logic [7:0] b);
        dsrm_pkg::item_t it;
        it = '0;
        it.command = cmd;
        it.rx_byte = b;
        return it;
    endfunction

    function automatic row_t make_row(input dsrm_pkg::item_t it, input row_kind_t kind,
                                      input dsrm_pkg::result_t want);
        row_t rw;
        rw.it = it;
        rw.kind = kind;
        rw.want = want;
        return rw;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    task automatic drive_item(input dsrm_pkg::item_t it, input row_kind_t kind,
                              input dsrm_pkg::result_t want);
        dsrm_pkg::result_t res;
        bit                has_res;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.command;
        s_axis_tdata <= {3'b000, it.capture_size, it.timeout_ticks, it.reject_length,
                         it.reject_pattern, it.accept_length, it.accept_pattern, it.rx_byte};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        has_res = matcher_response(it, res);
        case (kind)
            ROW_PREDICTED:
                if (has_res)
                    pending_responses.push_back(res);
            ROW_FIXED:
                pending_responses.push_back(want);
            default:
                ;
        endcase
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    task automatic log_mismatch(input string what, input dsrm_pkg::result_t want,
                                input dsrm_pkg::result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected done=%0d outcome=%0d valid=%0d byte=%02h,",
                     what, want.done_res, want.outcome, want.byte_valid,
                     want.captured_byte,
                     " got done=%0d outcome=%0d valid=%0d byte=%02h",
                     got.done_res, got.outcome, got.byte_valid, got.captured_byte);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk) cycle_count++;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        dsrm_pkg::result_t got;
        dsrm_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            got = {m_axis_tlast, m_axis_tuser[1:0], m_axis_tuser[2], m_axis_tdata};
            if (pending_responses.size() == 0)
                log_mismatch("unexpected item", '0, got);
            else
            begin
                want = pending_responses.pop_front();
                if (got.done_res !== want.done_res || got.outcome !== want.outcome ||
                    got.byte_valid !== want.byte_valid ||
                    got.captured_byte !== want.captured_byte)
                    log_mismatch("mismatch", want, got);
            end
        end
    end

    // receiver: random ready, one long hold-off once results are flowing
    initial
    begin
        int  mode;
        int  span;
        bit  held_off;
        held_off = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && results_seen >= 100)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                held_off = 1'b1;
            end
            mode = $urandom_range(0, 99);
            if (mode < 50)
            begin
                span = $urandom_range(1, 30);
                repeat (span)
                begin
                    @(negedge clk);
                    m_axis_tready <= ($urandom_range(0, 3) != 0);
                end
            end
            else if (mode < 80)
            begin
                span = $urandom_range(1, 40);
                repeat (span)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b1;
                end
            end
            else
            begin
                span = (mode < 95) ? $urandom_range(1, 5) : $urandom_range(20, 80);
                repeat (span)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        row_t              table_rows[$];
        dsrm_pkg::item_t   it;
        dsrm_pkg::result_t none;
        int                sent;
        int                sessions;
        int                span;
        int                r;

        none = '0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = dsrm_pkg::CMD_START;

        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h41), ROW_SILENT, none));
        table_rows.push_back(make_row(rx_item(CMD_UNUSED, 8'h41), ROW_SILENT, none));
        table_rows.push_back(make_row(start_item(64'h4B4F, 4'd2, 64'h5245, 4'd2, 16'd5, 5'd2),
                                      ROW_SILENT, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h45),
                                      ROW_PREDICTED, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, dsrm_pkg::BYTE_IGNORE),
                                      ROW_SILENT, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h4F),
                                      ROW_PREDICTED, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h4B),
                                      ROW_PREDICTED, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h00), ROW_FIXED,
                                      '{1'b0, dsrm_pkg::OUTCOME_TIMEOUT, 1'b1, 8'h00}));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h80), ROW_FIXED,
                                      '{1'b1, dsrm_pkg::OUTCOME_ACCEPT, 1'b1, 8'h80}));
        table_rows.push_back(make_row(start_item('1, 4'hF, '1, 4'hF, 16'd0, 5'h1F),
                                      ROW_SILENT, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_TICK, 8'h00), ROW_FIXED,
                                      '{1'b1, dsrm_pkg::OUTCOME_TIMEOUT, 1'b0, 8'h00}));
        table_rows.push_back(make_row(start_item(64'h4241, 4'd2, 64'h4241, 4'd2, 16'hFFFF,
                                                 5'd0), ROW_SILENT, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h41),
                                      ROW_PREDICTED, none));
        table_rows.push_back(make_row(start_item(64'h4241, 4'd2, 64'h4241, 4'd2, 16'hFFFF,
                                                 5'd0), ROW_SILENT, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h42),
                                      ROW_PREDICTED, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h41),
                                      ROW_PREDICTED, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h42), ROW_FIXED,
                                      '{1'b1, dsrm_pkg::OUTCOME_REJECT, 1'b0, 8'h00}));
        table_rows.push_back(make_row(start_item(64'h41, 4'd1, 64'hA5A5_5A5A_0F0F_F0F0, 4'd0,
                                                 16'd1, 5'd16), ROW_SILENT, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h41),
                                      ROW_PREDICTED, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_TICK, 8'h00),
                                      ROW_PREDICTED, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_TICK, 8'h00), ROW_FIXED,
                                      '{1'b1, dsrm_pkg::OUTCOME_ACCEPT, 1'b0, 8'h00}));
        table_rows.push_back(make_row(start_item(64'h41, 4'd1, 64'h0, 4'd0, 16'd3, 5'd4),
                                      ROW_SILENT, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h41),
                                      ROW_PREDICTED, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, dsrm_pkg::BYTE_CR),
                                      ROW_FIXED,
                                      '{1'b1, dsrm_pkg::OUTCOME_ACCEPT, 1'b0, 8'h00}));
        table_rows.push_back(make_row(start_item(64'h41, 4'd0, 64'h41, 4'd1, 16'd0, 5'd3),
                                      ROW_SILENT, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_BYTE, 8'h41), ROW_SILENT, none));
        table_rows.push_back(make_row(rx_item(dsrm_pkg::CMD_TICK, 8'h00), ROW_FIXED,
                                      '{1'b1, dsrm_pkg::OUTCOME_TIMEOUT, 1'b0, 8'h00}));

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (table_rows[i])
        begin
            drive_item(table_rows[i].it, table_rows[i].kind, table_rows[i].want);
            pause_sender(pick_gap());
        end

        sent = 0;
        sessions = 0;
        while (sent < RANDOM_ITEMS)
        begin
            it = random_item();
            it.command = dsrm_pkg::CMD_START;
            r = $urandom_range(0, 99);
            it.accept_length = (r < 5) ? 4'd0 :
                               (r < 90) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(5, 15));
            r = $urandom_range(0, 99);
            it.reject_length = (r < 40) ? 4'd0 :
                               (r < 95) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(9, 15));
            if ($urandom_range(0, 9) == 0)
            begin
                it.reject_pattern = it.accept_pattern;
                it.reject_length = it.accept_length;
            end
            r = $urandom_range(0, 99);
            it.timeout_ticks = (r < 70) ? 16'($urandom_range(0, 30)) :
                               (r < 90) ? 16'($urandom_range(31, 300)) : 16'($urandom);
            r = $urandom_range(0, 99);
            it.capture_size = (r < 20) ? 5'd0 :
                              (r < 85) ? 5'($urandom_range(1, 6)) :
                              (r < 95) ? 5'($urandom_range(7, 16)) : 5'($urandom_range(17, 31));
            drive_item(it, ROW_PREDICTED, none);
            sent++;
            pause_sender(pick_gap());

            span = $urandom_range(3, 40);
            for (int k = 0; k < span && wait_state != WAIT_IDLE; k++)
            begin
                it = random_item();
                it.command = dsrm_pkg::CMD_BYTE;
                r = $urandom_range(0, 99);
                if (r < 40)
                begin
                    if (wait_state == WAIT_MATCH)
                        it.rx_byte = held_acc[8*acc_pos[2:0] +: 8];
                end
                else if (r < 52)
                    it.rx_byte = held_rej[8*rej_pos[2:0] +: 8];
                else if (r < 64)
                    ;
                else if (r < 70)
                    it.rx_byte = r[0] ? dsrm_pkg::BYTE_CR : dsrm_pkg::BYTE_LF;
                else if (r < 73)
                    it.rx_byte = dsrm_pkg::BYTE_IGNORE;
                else if (r < 93)
                    it.command = dsrm_pkg::CMD_TICK;
                else if (r < 95)
                    it.command = CMD_UNUSED;
                if (it.command != CMD_UNUSED)
                    sent++;
                drive_item(it, ROW_PREDICTED, none);
                pause_sender(pick_gap());
            end

            sessions++;
            if (sessions % 40 == 0)
            begin
                pause_sender(1);
                while (pending_responses.size() != 0)
                    @(posedge clk);
            end
        end

        pause_sender(1);
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
